// ===== rtl/assert_macros.svh =====
// Assertion macros for the split-step phase operator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset
`define ASSERT_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/ssp_pkg.sv =====
// Shared constants and types for the split-step phase operator.
// No dependencies; imported by ssp_divc and the top level.
package ssp_pkg;

    // Series length and number of angle doublings
    localparam int TAYLOR_TERMS = 10;
    localparam int SQUARINGS    = 20;

    // 1.0 in Q2.62
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    // Constant divider: remainder width, stage count, bytes retired per stage
    localparam int DIV_RW              = 4;
    localparam int DIV_STAGES          = 4;
    localparam int DIV_BYTES_PER_STAGE = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIME_STEP      = 2'd0,
        CFG_TRAP_ENABLE    = 2'd1,
        CFG_REAL_TIME_MODE = 2'd2
    } cfg_index_t;

    // Values that ride along the series pipeline
    typedef struct packed {
        logic [63:0] u;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] e;
    } taylor_side_t;

endpackage

// ===== rtl/ssp_mulq.sv =====
// Three-stage Q2.62 magnitude multiplier, rounded to nearest, ties up.
// Carries a sideband vector alongside; uses no package items.
module ssp_mulq #(
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_in,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic [63:0]   prod,
    output logic [SW-1:0] side_out
);

    logic [2:0]    vld_reg;
    logic [63:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]   ll2_reg, hh2_reg;
    logic [64:0]   mid_reg;
    logic [SW-1:0] side1_reg, side2_reg, side3_reg;
    logic [63:0]   prod_reg;
    logic [127:0]  full_next;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    // Stage 1: four 32x32 partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg    <= 64'(a[31:0])  * 64'(b[31:0]);
            lh_reg    <= 64'(a[31:0])  * 64'(b[63:32]);
            hl_reg    <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg    <= 64'(a[63:32]) * 64'(b[63:32]);
            side1_reg <= side_in;
        end
    end

    // Stage 2: fold the cross terms
    always_ff @(posedge aclk) begin
        if (en) begin
            ll2_reg   <= ll_reg;
            hh2_reg   <= hh_reg;
            mid_reg   <= 65'(lh_reg) + 65'(hl_reg);
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: full sum, add half an LSB, keep bits 125..62
    assign full_next = {hh2_reg, 64'h0} + {31'h0, mid_reg, 32'h0} + {64'h0, ll2_reg}
                     + 128'h2000_0000_0000_0000;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= full_next[125:62];
            side3_reg <= side2_reg;
        end
    end

    assign vld_out  = vld_reg[2];
    assign prod     = prod_reg;
    assign side_out = side3_reg;

endmodule

// ===== rtl/ssp_divc.sv =====
// Pipelined truncating divide of a 64-bit value by a small constant.
// Depends on ssp_pkg for stage count and remainder width.
module ssp_divc #(
    parameter int K  = 3,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          vld_in,
    input  logic [63:0]   dividend,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic [63:0]   quotient,
    output logic [SW-1:0] side_out
);
    import ssp_pkg::*;

    // Reciprocal exact for digit values below 2^12 and K up to 10
    localparam int                RECIP   = (65536 + K - 1) / K;
    localparam logic [16:0]       RECIP_C = 17'(RECIP);
    localparam logic [DIV_RW-1:0] DIVISOR = DIV_RW'(K);

    logic [63:0]       x_reg    [DIV_STAGES];
    logic [63:0]       q_reg    [DIV_STAGES];
    logic [DIV_RW-1:0] r_reg    [DIV_STAGES];
    logic [SW-1:0]     side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [63:0]       x_cur, q_cur, x_next, q_next;
        logic [DIV_RW-1:0] r_cur, r_next;
        logic [SW-1:0]     sd_cur;
        logic              v_cur;
        logic [DIV_RW+7:0] v12;
        logic [DIV_RW+24:0] rprod;
        logic [7:0]        qd;
        logic [DIV_RW+7:0] rem;

        if (g == 0) begin : g_first
            assign x_cur  = dividend;
            assign q_cur  = '0;
            assign r_cur  = '0;
            assign sd_cur = side_in;
            assign v_cur  = vld_in;
        end else begin : g_rest
            assign x_cur  = x_reg[g-1];
            assign q_cur  = q_reg[g-1];
            assign r_cur  = r_reg[g-1];
            assign sd_cur = side_reg[g-1];
            assign v_cur  = vld_reg[g-1];
        end

        // Retire bytes MSB first: quotient digit by reciprocal, remainder by back-multiply
        always_comb begin
            x_next = x_cur;
            q_next = q_cur;
            r_next = r_cur;
            v12    = '0;
            rprod  = '0;
            qd     = '0;
            rem    = '0;
            for (int b = 0; b < DIV_BYTES_PER_STAGE; b++) begin
                v12    = {r_next, x_next[63:56]};
                rprod  = (DIV_RW + 25)'(v12) * (DIV_RW + 25)'(RECIP_C);
                qd     = rprod[23:16];
                rem    = v12 - (DIV_RW + 8)'((DIV_RW + 8)'(qd) * (DIV_RW + 8)'(DIVISOR));
                r_next = rem[DIV_RW-1:0];
                q_next = {q_next[55:0], qd};
                x_next = {x_next[55:0], 8'h00};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g]    <= x_next;
                q_reg[g]    <= q_next;
                r_reg[g]    <= r_next;
                side_reg[g] <= sd_cur;
            end
        end
    end

    assign vld_out  = vld_reg[DIV_STAGES-1];
    assign quotient = q_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/split_step_phase_operator_unit.sv =====
// Top level of the split-step phase operator: energy, theta, series, squarings.
// Depends on ssp_pkg, ssp_mulq, ssp_divc and assert_macros.svh.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: op; tdata: point_energy, trap_energy
//  m_       | out | m_tvalid/m_tready  | tdata: real_part, imag_part
//  cfg_     | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// One item per cycle sustained while the skid register is empty.
// Depth is set by 10 series terms (3-stage multiply + 4-stage divide each) and
// 20 squaring rounds (3-stage multiply + combine each).
// aresetn is synchronous, active low; it clears valid bits and restores the configuration registers.
// The whole pipeline stalls only when the skid register is occupied.
`include "assert_macros.svh"

module split_step_phase_operator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] point_energy, [63:32] trap_energy
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] real_part, [63:32] imag_part
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import ssp_pkg::*;

    localparam int SIDE_W = $bits(taylor_side_t);

    // Add one series term into the running sums
    function automatic taylor_side_t acc_term(input taylor_side_t sd, input logic [63:0] t,
                                              input int j);
        taylor_side_t r;
        r = sd;
        case (2'(j))
            2'd0:    r.c = r.c + t;
            2'd1:    r.s = r.s + t;
            2'd2:    r.c = r.c - t;
            default: r.s = r.s - t;
        endcase
        if (j[0]) begin
            r.e = r.e - t;
        end else begin
            r.e = r.e + t;
        end
        return r;
    endfunction

    // Q2.62 to Q1.30: round magnitude, clamp at one, restore sign
    function automatic logic [31:0] to_q30(input logic [63:0] x);
        logic [63:0] mag;
        logic [64:0] sum;
        logic [32:0] r;
        mag = x[63] ? (64'h0 - x) : x;
        sum = 65'(mag) + 65'h0_8000_0000;
        r   = sum[64:32];
        if (r > 33'h0_4000_0000) begin
            r = 33'h0_4000_0000;
        end
        return x[63] ? (32'h0 - r[31:0]) : r[31:0];
    endfunction

    logic [31:0] time_step_reg;
    logic        trap_enable_reg;
    logic        real_time_mode_reg;
    logic        adv;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg      <= 32'd429497;
            trap_enable_reg    <= 1'b1;
            real_time_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TIME_STEP:      time_step_reg      <= cfg_wdata;
                CFG_TRAP_ENABLE:    trap_enable_reg    <= cfg_wdata[0];
                CFG_REAL_TIME_MODE: real_time_mode_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Stage A: saturating energy sum
    logic        a_vld_reg, a_op_reg;
    logic [31:0] a_energy_reg, a_energy_next;
    logic [32:0] a_sum;

    always_comb begin
        a_sum = 33'(s_tdata[31:0]);
        if (!s_tuser && trap_enable_reg) begin
            a_sum = a_sum + 33'(s_tdata[63:32]);
        end
        a_energy_next = a_sum[32] ? 32'hFFFF_FFFF : a_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg     <= s_tuser;
            a_energy_reg <= a_energy_next;
        end
    end

    // Stage B: theta product
    logic        b_vld_reg, b_op_reg;
    logic [63:0] b_prod_reg;
    logic [63:0] u_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_op_reg   <= a_op_reg;
            b_prod_reg <= 64'(a_energy_reg) * 64'(time_step_reg);
        end
    end

    // Position theta is halved; scale by 2^-20 for the series
    assign u_val = b_op_reg ? (b_prod_reg >> 6) : (b_prod_reg >> 7);

    // Series chain: multiply by u, divide by term number, accumulate
    logic         t_vld  [TAYLOR_TERMS+1];
    logic [63:0]  t_term [TAYLOR_TERMS+1];
    taylor_side_t t_side [TAYLOR_TERMS+1];

    assign t_vld[0]  = b_vld_reg;
    assign t_term[0] = ONE_Q62;
    assign t_side[0] = '{u: u_val, c: 64'h0, s: 64'h0, e: 64'h0};

    for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
        taylor_side_t acc;
        logic         mv;
        logic [63:0]  mp;
        logic [SIDE_W-1:0] ms;

        assign acc = acc_term(t_side[g], t_term[g], g);

        ssp_mulq #(.SW(SIDE_W)) u_mul (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (t_vld[g]),
            .a        (t_term[g]),
            .b        (t_side[g].u),
            .side_in  (acc),
            .vld_out  (mv),
            .prod     (mp),
            .side_out (ms)
        );

        ssp_divc #(.K(g + 1), .SW(SIDE_W)) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (mv),
            .dividend (mp),
            .side_in  (ms),
            .vld_out  (t_vld[g+1]),
            .quotient (t_term[g+1]),
            .side_out (t_side[g+1])
        );
    end

    // Prep stage: last term, then pick cos/sin or exp as the squaring seed
    logic         sq_vld_reg [SQUARINGS+1];
    logic [63:0]  sq_c_reg   [SQUARINGS+1];
    logic [63:0]  sq_s_reg   [SQUARINGS+1];
    taylor_side_t fin;

    assign fin = acc_term(t_side[TAYLOR_TERMS], t_term[TAYLOR_TERMS], TAYLOR_TERMS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= t_vld[TAYLOR_TERMS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_c_reg[0] <= real_time_mode_reg ? fin.c : fin.e;
            sq_s_reg[0] <= real_time_mode_reg ? fin.s : 64'h0;
        end
    end

    // Squaring rounds: (c, s) <- (c*c - s*s, 2*c*s); exp rides with s at zero
    for (genvar g = 0; g < SQUARINGS; g++) begin : g_sq
        logic [63:0] mag_c, mag_s;
        logic        neg;
        logic        m0v, nsign;
        logic [63:0] p0, p1, p2;

        assign mag_c = sq_c_reg[g][63] ? (64'h0 - sq_c_reg[g]) : sq_c_reg[g];
        assign mag_s = sq_s_reg[g][63] ? (64'h0 - sq_s_reg[g]) : sq_s_reg[g];
        assign neg   = sq_c_reg[g][63] ^ sq_s_reg[g][63];

        ssp_mulq #(.SW(1)) u_cc (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (sq_vld_reg[g]),
            .a        (mag_c),
            .b        (mag_c),
            .side_in  (neg),
            .vld_out  (m0v),
            .prod     (p0),
            .side_out ()
        );

        ssp_mulq #(.SW(1)) u_ss (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (sq_vld_reg[g]),
            .a        (mag_s),
            .b        (mag_s),
            .side_in  (neg),
            .vld_out  (),
            .prod     (p1),
            .side_out ()
        );

        ssp_mulq #(.SW(1)) u_cs (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .vld_in   (sq_vld_reg[g]),
            .a        (mag_c),
            .b        (mag_s),
            .side_in  (neg),
            .vld_out  (),
            .prod     (p2),
            .side_out (nsign)
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[g+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[g+1] <= m0v;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_c_reg[g+1] <= p0 - p1;
                sq_s_reg[g+1] <= (nsign ? (64'h0 - p2) : p2) << 1;
            end
        end
    end

    // Output stage: convert to Q1.30
    logic        o_vld_reg;
    logic [63:0] o_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (adv) begin
            o_vld_reg <= sq_vld_reg[SQUARINGS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_data_reg <= {to_q30(64'h0 - sq_s_reg[SQUARINGS]), to_q30(sq_c_reg[SQUARINGS])};
        end
    end

    // Output register plus skid: the pipeline halts only while the skid is full
    logic        out_vld_reg, skid_vld_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic        push, pop;

    assign adv  = !skid_vld_reg;
    assign push = adv && o_vld_reg;
    assign pop  = out_vld_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg  <= skid_vld_reg;
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            if (!out_vld_reg || pop) begin
                out_data_reg <= o_data_reg;
            end else begin
                skid_data_reg <= o_data_reg;
            end
        end else if (pop) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `ASSERT_IMPLY(a_skid_needs_out, aclk, aresetn, skid_vld_reg, out_vld_reg, "skid full with empty output register")
    `ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_vld_reg && !m_tready, skid_vld_reg, "skid item lost while stalled")
    `ASSERT_IMPLY(a_imag_zero, aclk, aresetn, out_vld_reg && !real_time_mode_reg, m_tdata[63:32] == 32'h0, "nonzero imaginary part in imaginary time")
    `ASSERT_IMPLY(a_real_clamp, aclk, aresetn, out_vld_reg, ($signed(m_tdata[31:0]) <= 32'sh4000_0000) && ($signed(m_tdata[31:0]) >= -32'sh4000_0000), "real part beyond one")

endmodule
